@@ sv/http_chunked_body_decoder_macros.svh @@
// Assertion macros for the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Checked only out of reset.
`define HCBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define HCBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/hcbd_pkg.sv @@
package hcbd_pkg;

  localparam int unsigned LenWidth = 32;

  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7a;
  localparam logic [7:0] CaseShift = 8'd32;
  localparam logic [7:0] LetterOff = 8'd10;

  localparam logic [1:0] TrailBytes = 2'd2;

  typedef enum logic [4:0] {
    PhLine  = 5'b00001,
    PhSkipLf = 5'b00010,
    PhData  = 5'b00100,
    PhTrail = 5'b01000,
    PhDone  = 5'b10000
  } phase_e;

  function automatic logic [3:0] hex_digit(input logic [7:0] ch);
    logic [7:0] up;
    logic [7:0] val;
    up = ch;
    if (ch >= CharLowA && ch <= CharLowZ) begin
      up = ch - CaseShift;
    end
    if (up > CharNine) begin
      val = up - CharUpA + LetterOff;
    end else begin
      val = up - CharZero;
    end
    return val[3:0];
  endfunction

endpackage

@@ sv/http_chunked_body_decoder.sv @@
// Chunked transfer decoder for an HTTP response body.
// Input channel (in_valid_i/in_ready_o) carries one body byte per
// transaction plus start_body_i, which restarts decoding at a chunk length
// line before that byte is handled. Output channel (out_valid_o/out_ready_i)
// carries zero or one result per input byte: a payload byte (kind_o = 0,
// chunk_last_o marks the final byte of a chunk) or an end-of-body marker
// (kind_o = 1, on the LF of a zero length line); other bytes give no result.
// A result is registered: it appears in the cycle after its byte is taken.
// Throughput is one byte per cycle unless the receiver stalls; the decode is
// a single state update between the input handshake and the output register.
// When the receiver stalls, the pending result holds in the output register
// and in_ready_o drops, so at most one result waits at a time.
// Reset (rst_ni low, asynchronous) empties the output register and returns
// the decoder to reading a length line with all counts cleared.
module http_chunked_body_decoder
  import hcbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       start_body_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] out_byte_o,
  output logic       chunk_last_o
);

  `include "http_chunked_body_decoder_macros.svh"

  phase_e                phase_q, phase_d;
  logic [LenWidth-1:0]   accum_q, accum_d;
  logic [LenWidth-1:0]   rem_q, rem_d;
  logic [1:0]            skip_q, skip_d;

  logic                  out_valid_q, out_valid_d;
  logic                  kind_q, kind_d;
  logic [7:0]            byte_q, byte_d;
  logic                  last_q, last_d;

  phase_e                ph_eff;
  logic [LenWidth-1:0]   accum_eff;
  logic [LenWidth-1:0]   rem_eff;
  logic [1:0]            skip_eff;
  logic [LenWidth-1:0]   rem_dec;
  logic [1:0]            skip_dec;
  logic                  in_fire;
  logic                  res_valid;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    ph_eff    = phase_q;
    accum_eff = accum_q;
    rem_eff   = rem_q;
    skip_eff  = skip_q;
    if (start_body_i) begin
      ph_eff    = PhLine;
      accum_eff = '0;
      rem_eff   = '0;
      skip_eff  = '0;
    end
    rem_dec  = rem_eff - {{(LenWidth-1){1'b0}}, 1'b1};
    skip_dec = skip_eff - 2'd1;

    phase_d   = ph_eff;
    accum_d   = accum_eff;
    rem_d     = rem_eff;
    skip_d    = skip_eff;
    res_valid = 1'b0;
    kind_d    = 1'b0;
    byte_d    = 8'h00;
    last_d    = 1'b0;

    case (ph_eff)
      PhLine: begin
        if (in_byte_i == CharCr) begin
          phase_d = PhSkipLf;
        end else begin
          accum_d = {accum_eff[LenWidth-5:0], hex_digit(in_byte_i)};
        end
      end
      PhSkipLf: begin
        if (accum_eff == '0) begin
          phase_d   = PhDone;
          res_valid = 1'b1;
          kind_d    = 1'b1;
        end else begin
          rem_d   = accum_eff;
          phase_d = PhData;
        end
      end
      PhData: begin
        rem_d     = rem_dec;
        res_valid = 1'b1;
        byte_d    = in_byte_i;
        last_d    = (rem_dec == '0);
        if (rem_dec == '0) begin
          phase_d = PhTrail;
          skip_d  = TrailBytes;
        end
      end
      PhTrail: begin
        skip_d = skip_dec;
        if (skip_dec == 2'd0) begin
          phase_d = PhLine;
          accum_d = '0;
        end
      end
      default: begin
        phase_d = PhDone;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLine;
      accum_q     <= '0;
      rem_q       <= '0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q <= phase_d;
        accum_q <= accum_d;
        rem_q   <= rem_d;
        skip_q  <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign out_byte_o   = byte_q;
  assign chunk_last_o = last_q;

  `HCBD_ASSERT_ALWAYS(a_stall_blocks_input, (out_valid_q && !out_ready_i) |-> !in_ready_o, "input taken while result stalled")
  `HCBD_ASSERT(a_data_has_bytes, (phase_q == PhData) |-> (rem_q != '0), "data phase with no bytes left")
  `HCBD_ASSERT(a_trail_has_skip, (phase_q == PhTrail) |-> (skip_q != 2'd0), "trailer phase with nothing to skip")
  `HCBD_ASSERT(a_end_has_no_data, (out_valid_q && kind_q) |-> (byte_q == 8'h00 && !last_q), "end result carries data")

endmodule
